[rtl/utf8dec_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package utf8dec_pkg;

    localparam int MAX_UNITS = 5;
    localparam int SLOT_W    = $clog2(MAX_UNITS);

    localparam logic [15:0] REPLACEMENT_RESET = 16'h0020;
    localparam logic [20:0] SUPP_BASE         = 21'h010000;
    localparam logic [15:0] HIGH_SURR_BASE    = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE     = 16'hDC00;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [2:0]  expected_length;
        logic [1:0]  bytes_taken;
        logic [20:0] partial_point;
        logic        stopped_by_zero;
    } dec_state_t;

    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [SLOT_W-1:0]          count;
        logic                       term;
    } unit_plan_t;

endpackage

[rtl/utf8dec_decode.sv]
// Combinational decode of one source byte into a list of code units and the next state.
module utf8dec_decode
    import utf8dec_pkg::*;
(
    input  dec_state_t  state_cur,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    input  logic [15:0] replacement_unit,
    output dec_state_t  state_next,
    output unit_plan_t  plan
);

    logic [1:0]  pre_n;
    logic [1:0]  mid_n;
    logic [1:0]  post_n;
    logic [15:0] mid0;
    logic [15:0] mid1;
    logic        lead_now;
    logic [2:0]  taken;
    logic [20:0] point_ext;
    logic [20:0] supp;
    dec_state_t  st;

    always_comb begin
        st        = state_cur;
        pre_n     = 2'd0;
        mid_n     = 2'd0;
        post_n    = 2'd0;
        mid0      = 16'h0000;
        mid1      = 16'h0000;
        lead_now  = 1'b0;
        taken     = {1'b0, state_cur.bytes_taken} + 3'd1;
        point_ext = {state_cur.partial_point[14:0], data_byte[5:0]};
        supp      = point_ext - SUPP_BASE;

        if (!state_cur.stopped_by_zero) begin
            if (state_cur.expected_length != LEN_NONE) begin
                if (data_byte[7:6] == 2'b10) begin
                    if (taken >= state_cur.expected_length) begin
                        st.expected_length = LEN_NONE;
                        st.bytes_taken     = 2'd0;
                        st.partial_point   = 21'd0;
                        if (point_ext[20:16] == 5'd0) begin
                            mid_n = 2'd1;
                            mid0  = point_ext[15:0];
                        end else begin
                            mid_n = 2'd2;
                            mid0  = HIGH_SURR_BASE | {5'd0, supp[20:10]};
                            mid1  = LOW_SURR_BASE | {6'd0, supp[9:0]};
                        end
                    end else begin
                        st.bytes_taken   = taken[1:0];
                        st.partial_point = point_ext;
                    end
                end else begin
                    pre_n              = state_cur.bytes_taken;
                    st.expected_length = LEN_NONE;
                    st.bytes_taken     = 2'd0;
                    st.partial_point   = 21'd0;
                    lead_now           = 1'b1;
                end
            end else begin
                lead_now = 1'b1;
            end
        end

        if (lead_now) begin
            if (!data_byte[7]) begin
                if (data_byte == 8'h00) begin
                    st.stopped_by_zero = 1'b1;
                end else begin
                    mid_n = 2'd1;
                    mid0  = {8'h00, data_byte};
                end
            end else if (data_byte[7:5] == 3'b110) begin
                st.expected_length = LEN_TWO;
                st.bytes_taken     = 2'd1;
                st.partial_point   = {16'd0, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
                st.expected_length = LEN_THREE;
                st.bytes_taken     = 2'd1;
                st.partial_point   = {17'd0, data_byte[3:0]};
            end else if (data_byte[7:3] == 5'b11110) begin
                st.expected_length = LEN_FOUR;
                st.bytes_taken     = 2'd1;
                st.partial_point   = {18'd0, data_byte[2:0]};
            end else begin
                mid_n = 2'd1;
                mid0  = replacement_unit;
            end
        end

        if (end_of_text) begin
            if (st.expected_length != LEN_NONE) begin
                post_n = st.bytes_taken;
            end
            st.expected_length = LEN_NONE;
            st.bytes_taken     = 2'd0;
            st.partial_point   = 21'd0;
            st.stopped_by_zero = 1'b0;
        end

        state_next = st;
    end

    always_comb begin
        logic [SLOT_W-1:0] pre_end;
        logic [SLOT_W-1:0] mid_end;
        logic [SLOT_W-1:0] post_end;
        logic [SLOT_W-1:0] slot;
        pre_end  = SLOT_W'(pre_n);
        mid_end  = pre_end + SLOT_W'(mid_n);
        post_end = mid_end + SLOT_W'(post_n);
        for (int i = 0; i < MAX_UNITS; i++) begin
            slot = SLOT_W'(i);
            if (slot < pre_end) begin
                plan.units[i] = replacement_unit;
            end else if (slot < mid_end) begin
                plan.units[i] = (slot == pre_end) ? mid0 : mid1;
            end else if (slot < post_end) begin
                plan.units[i] = replacement_unit;
            end else begin
                plan.units[i] = 16'h0000;
            end
        end
        plan.count = post_end + SLOT_W'(end_of_text);
        plan.term  = end_of_text;
    end

endmodule

[rtl/utf8_to_utf16_decoder_unit.sv]
// Top level of the UTF-8 to UTF-16 decoder: input decode, unit list register and output sequencer.
//
// The slave channel takes one UTF-8 source byte per word in s_tdata; s_tlast marks the
// final byte of the buffer. The master channel gives one UTF-16 code unit per word,
// together with the running unit count; m_tuser flags the zero terminator that follows
// the final byte, and m_tlast marks the last word caused by one source byte.
// A byte is decoded in the cycle it is accepted and its words are held in a unit list
// register; the first word is presented in the cycle after acceptance. A byte's words
// then leave one at a time, at most five of them. The list register lets the next byte
// be accepted in the same cycle that the last word of the current byte is taken. The
// user must write the replacement unit through cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce this. A synchronous low aresetn
// clears the pending sequence, the unit count and the list valid flag and slot, and
// sets the replacement unit to a space. When the receiver holds m_tready low, the
// current word stays on the master channel and s_tready stays low until it is taken.
module utf8_to_utf16_decoder_unit
    import utf8dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code_unit[15:0], unit_count[47:16]
    output logic        m_tuser,   // is_terminator
    output logic        m_tlast
);

    dec_state_t        state_reg;
    dec_state_t        state_next;
    unit_plan_t        plan_reg;
    unit_plan_t        plan_next;
    logic              plan_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       count_reg;
    logic [31:0]       count_inc;
    logic [15:0]       replacement_reg;
    logic              s_accept;
    logic              m_accept;
    logic              last_slot;
    logic              is_term;
    logic [15:0]       unit_out;

    utf8dec_decode u_decode (
        .state_cur        (state_reg),
        .data_byte        (s_tdata),
        .end_of_text      (s_tlast),
        .replacement_unit (replacement_reg),
        .state_next       (state_next),
        .plan             (plan_next)
    );

    assign last_slot = (slot_reg == plan_reg.count - SLOT_W'(1));
    assign is_term   = plan_reg.term && last_slot;
    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
    assign unit_out  = is_term ? 16'h0000 : plan_reg.units[slot_reg];

    assign m_tvalid = plan_valid_reg;
    assign m_tdata  = {(is_term ? count_reg : count_inc), unit_out};
    assign m_tuser  = is_term;
    assign m_tlast  = last_slot;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = !plan_valid_reg || (m_tready && last_slot);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replacement_reg <= REPLACEMENT_RESET;
        end else if (cfg_we) begin
            replacement_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            slot_reg       <= '0;
        end else if (s_accept) begin
            plan_valid_reg <= (plan_next.count != '0);
            slot_reg       <= '0;
        end else if (m_accept) begin
            if (last_slot) begin
                plan_valid_reg <= 1'b0;
            end else begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            plan_reg <= plan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 32'd0;
        end else if (m_accept) begin
            count_reg <= is_term ? 32'd0 : count_inc;
        end
    end

endmodule

[tb/tb_utf8_to_utf16_decoder_unit.sv]
// Self-checking testbench: UTF-8 bytes in, predicted UTF-16 code unit words compared out.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder_unit;
    import utf8dec_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [15:0] code_unit;
        logic        is_terminator;
        logic [31:0] unit_count;
        logic        last_of_run;
    } unit_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Predicted decoder state and the code units still owed by the block.
    logic [15:0] repl_unit = REPLACEMENT_RESET;
    logic [2:0]  seq_len = LEN_NONE;
    logic [1:0]  seq_taken = 2'd0;
    logic [20:0] seq_point = 21'd0;
    logic        halted = 1'b0;
    logic [31:0] unit_tally = 32'd0;
    unit_word_t  units_due[$];

    logic        src_gaps = 1'b0;
    logic        sink_stalls = 1'b0;
    int          errors = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          words_checked = 0;
    int          frames_sent = 0;
    int          repl_settings = 1;

    utf8_to_utf16_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("utf8_to_utf16_decoder_unit regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= sink_stalls ? ($urandom_range(0, 99) >= 15) : 1'b1;
        end
    end

    function automatic void emit_unit(input logic [15:0] unit, input logic term);
        unit_word_t w;
        if (!term && unit_tally != 32'hFFFF_FFFF) begin
            unit_tally++;
        end
        w.code_unit = term ? 16'h0000 : unit;
        w.is_terminator = term;
        w.unit_count = unit_tally;
        w.last_of_run = 1'b0;
        units_due.push_back(w);
    endfunction

    function automatic void clear_seq();
        seq_len = LEN_NONE;
        seq_taken = 2'd0;
        seq_point = 21'd0;
    endfunction

    function automatic void flush_seq();
        for (int k = 0; k < seq_taken; k++) begin
            emit_unit(repl_unit, 1'b0);
        end
        clear_seq();
    endfunction

    function automatic void open_lead(input logic [7:0] b);
        if (!b[7]) begin
            if (b == 8'h00) begin
                halted = 1'b1;
            end else begin
                emit_unit({8'h00, b}, 1'b0);
            end
        end else if (b[7:5] == 3'b110) begin
            seq_len = LEN_TWO;
            seq_taken = 2'd1;
            seq_point = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            seq_len = LEN_THREE;
            seq_taken = 2'd1;
            seq_point = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            seq_len = LEN_FOUR;
            seq_taken = 2'd1;
            seq_point = {18'd0, b[2:0]};
        end else begin
            emit_unit(repl_unit, 1'b0);
        end
    endfunction

    function automatic void emit_point(input logic [20:0] cp);
        logic [20:0] off;
        if (cp <= 21'h00FFFF) begin
            emit_unit(cp[15:0], 1'b0);
        end else begin
            off = cp - SUPP_BASE;
            emit_unit(HIGH_SURR_BASE | {5'd0, off[20:10]}, 1'b0);
            emit_unit(LOW_SURR_BASE | {6'd0, off[9:0]}, 1'b0);
        end
    endfunction

    // Works out every word that one accepted source byte should produce.
    function automatic void transcode_byte(input logic [7:0] b, input logic eot);
        int          first;
        logic [2:0]  next_taken;
        logic [20:0] cp;
        first = units_due.size();
        if (!halted) begin
            if (seq_len != LEN_NONE) begin
                if (b[7:6] == 2'b10) begin
                    next_taken = {1'b0, seq_taken} + 3'd1;
                    seq_point = {seq_point[14:0], b[5:0]};
                    if (next_taken >= seq_len) begin
                        cp = seq_point;
                        clear_seq();
                        emit_point(cp);
                    end else begin
                        seq_taken = next_taken[1:0];
                    end
                end else begin
                    flush_seq();
                    open_lead(b);
                end
            end else begin
                open_lead(b);
            end
        end
        if (eot) begin
            if (seq_len != LEN_NONE) begin
                flush_seq();
            end
            emit_unit(16'h0000, 1'b1);
            clear_seq();
            halted = 1'b0;
            unit_tally = 32'd0;
        end
        if (units_due.size() > first) begin
            units_due[units_due.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        unit_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (units_due.size() == 0) begin
                $error("unexpected word: code_unit %h terminator %b", m_tdata[15:0], m_tuser);
                errors++;
            end else begin
                w = units_due.pop_front();
                words_checked++;
                if (m_tdata[15:0] !== w.code_unit) begin
                    $error("code_unit expected %h actual %h", w.code_unit, m_tdata[15:0]);
                    errors++;
                end
                if (m_tuser !== w.is_terminator) begin
                    $error("is_terminator expected %b actual %b", w.is_terminator, m_tuser);
                    errors++;
                end
                if (m_tdata[47:16] !== w.unit_count) begin
                    $error("unit_count expected %0d actual %0d", w.unit_count, m_tdata[47:16]);
                    errors++;
                end
                if (m_tlast !== w.last_of_run) begin
                    $error("last_of_run expected %b actual %b", w.last_of_run, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (src_gaps && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eot;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        transcode_byte(b, eot);
        bytes_sent++;
        if (eot) begin
            frames_sent++;
        end
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input logic eot_on_last);
        foreach (seq[i]) begin
            send_byte(seq[i], eot_on_last && (i == seq.size() - 1));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (units_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_replacement(input logic [15:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        repl_unit = value;
        repl_settings++;
    endtask

    function automatic void append_seq(ref logic [7:0] seq[$], input int len, input int conts);
        case (len)
            2: seq.push_back({3'b110, 5'($urandom_range(0, 31))});
            3: seq.push_back({4'b1110, 4'($urandom_range(0, 15))});
            default: seq.push_back({5'b11110, 3'($urandom_range(0, 7))});
        endcase
        for (int k = 0; k < conts; k++) begin
            seq.push_back({2'b10, 6'($urandom_range(0, 63))});
        end
    endfunction

    // Mostly well-formed characters with random content, plus some noise and broken sequences.
    task automatic send_frame(input int chars);
        logic [7:0] seq[$];
        int         pick;
        int         len;
        for (int c = 0; c < chars; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                seq.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 82) begin
                len = $urandom_range(2, 4);
                append_seq(seq, len, len - 1);
            end else if (pick < 90) begin
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                len = $urandom_range(2, 4);
                append_seq(seq, len, $urandom_range(0, len - 2));
            end else begin
                seq.push_back(8'h00);
            end
        end
        send_bytes(seq, $urandom_range(0, 9) != 0);
    endtask

    task automatic test_plain_ascii();
        send_bytes('{8'h01, 8'h7F}, 1'b1);
    endtask

    task automatic test_multibyte();
        send_bytes('{8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC}, 1'b0);
        send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
    endtask

    task automatic test_invalid_bytes();
        // An orphan continuation byte, an out-of-range lead, a lead cut short by ASCII, and a truncated tail.
        send_bytes('{8'h80, 8'hFF, 8'hE2, 8'h41, 8'hF0, 8'h9F}, 1'b1);
    endtask

    task automatic test_zero_stop();
        send_bytes('{8'hC2, 8'h00, 8'h41, 8'h42}, 1'b1);
    endtask

    task automatic test_drain_pause();
        for (int f = 0; f < 4; f++) begin
            send_frame($urandom_range(1, 5));
            wait_idle();
        end
    endtask

    task automatic test_random_traffic(input logic [15:0] repl, input int nbytes,
                                       input logic gaps, input logic stalls);
        int goal;
        write_replacement(repl);
        src_gaps = gaps;
        sink_stalls = stalls;
        goal = bytes_sent + nbytes;
        while (bytes_sent < goal) begin
            send_frame($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_ascii();
        test_multibyte();
        test_invalid_bytes();
        test_zero_stop();
        test_random_traffic(16'hFFFF, 60, 1'b1, 1'b1);
        test_drain_pause();
        test_random_traffic(16'h0000, 60, 1'b0, 1'b0);
        test_random_traffic(16'($urandom_range(0, 65535)), 60, 1'b1, 1'b1);
        test_random_traffic(16'hFFFD, 50, 1'b1, 1'b0);
        wait_idle();
        $display("Sent %0d source bytes in %0d terminated buffers; checked %0d words.",
                 bytes_sent, frames_sent, words_checked);
        $display("Used %0d replacement unit settings, with idle and back-pressure phases.",
                 repl_settings);
        if (errors == 0 && units_due.size() == 0) begin
            $display("utf8_to_utf16_decoder_unit regression: pass");
        end else begin
            $display("utf8_to_utf16_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/utf8dec_pkg.sv
rtl/utf8dec_decode.sv
rtl/utf8_to_utf16_decoder_unit.sv
tb/tb_utf8_to_utf16_decoder_unit.sv
